// ===== src/rkcb_pkg.sv =====
// ----------------------------------------------------------------------------
// rkcb_pkg: shared types and constants of the rolling k-mer binner
// Field widths, character and base codes, register indexes and queue sizing.
// ----------------------------------------------------------------------------
package rkcb_pkg;

    localparam int MAX_K      = 32;
    localparam int WIN_W      = 2 * MAX_K;
    localparam int SH_W       = $clog2(WIN_W) + 1;
    localparam int K_W        = 6;
    localparam int TC_W       = 17;
    localparam int TW_W       = 16;
    localparam int BIN_W      = 16;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int RED_W      = TC_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_WEIGHT = 2'd2;

    localparam logic [K_W-1:0]  WIN_LEN_RST   = 6'd31;
    localparam logic [TC_W-1:0] BIN_COUNT_RST = 17'd1;
    localparam logic [TC_W-1:0] MAX_BINS      = 17'd65536;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int MOD_STEPS = BIN_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    typedef struct packed {
        logic       bad;
        logic [1:0] code;
        logic       minimize;
    } t_item;

    typedef struct packed {
        logic [K_W-1:0]  win_len;
        logic [TC_W-1:0] bin_count;
        logic [TW_W-1:0] top_weight;
        logic            weight_stale;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWRED,
        ST_PREP,
        ST_RRED,
        ST_STEP1,
        ST_FIN
    } t_state;

endpackage

// ===== src/rkcb_in_if.sv =====
// ----------------------------------------------------------------------------
// rkcb_in_if: input character channel
// Valid/ready channel carrying one ASCII base and the minimize flag.
// ----------------------------------------------------------------------------
interface rkcb_in_if import rkcb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] base_char;
    logic              minimize;

    modport source (output valid, base_char, minimize, input ready);
    modport sink (input valid, base_char, minimize, output ready);
endinterface

// ===== src/rkcb_out_if.sv =====
// ----------------------------------------------------------------------------
// rkcb_out_if: result channel
// Valid/ready channel carrying one k-mer result word.
// ----------------------------------------------------------------------------
interface rkcb_out_if import rkcb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WIN_W-1:0]  forward_kmer;
    logic [WIN_W-1:0]  chosen_kmer;
    logic              was_reversed;
    logic [BIN_W-1:0]  bin_index;
    logic [CHAR_W-1:0] dropped_char;
    logic              bad_char;

    modport source (
        output valid, forward_kmer, chosen_kmer, was_reversed, bin_index, dropped_char,
        bad_char,
        input  ready
    );
    modport sink (
        input  valid, forward_kmer, chosen_kmer, was_reversed, bin_index, dropped_char,
        bad_char,
        output ready
    );
endinterface

// ===== src/rkcb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rkcb_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rkcb_cfg_if import rkcb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rolling_kmer_canonical_binner.sv =====
// ----------------------------------------------------------------------------
// rolling_kmer_canonical_binner: rolling k-mer window with canonical choice
// Usage:
//   i_in takes one ASCII character word (base_char, minimize) per handshake.
//   o_out gives one result word per input word: forward k-mer, reverse
//   complement or canonical minimum, reversed flag, bin, dropped character
//   and bad-character flag.
//   i_cfg writes the window length (0), the bin count (1) and top_weight (2);
//   it is always ready; the user must write it only while no word is in
//   flight, which the block itself does not enforce.
//   a word passes the front register, the queue and the back's state machine
//   into the output register; the back pops a new word only in IDLE, once
//   the last has left FIN for the output register. After a write of the bin
//   count or top_weight the next good character first reduces the weight in
//   the bit-serial remainder unit; a residue left at or above a new modulus
//   is reduced there as well.
// Reset clears the window to all A, the residue to zero and the registers to
// k = 31, one bin and weight zero. A stalled o_out holds its word; the
// back, queue and front keep taking up to four more words meanwhile.
// ----------------------------------------------------------------------------
module rolling_kmer_canonical_binner import rkcb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rkcb_in_if.sink    i_in,
    rkcb_cfg_if.sink   i_cfg,
    rkcb_out_if.source o_out
);

    logic [K_W-1:0]  r_win_len;
    logic [TC_W-1:0] r_bin_count;
    logic [TW_W-1:0] r_top_weight;
    logic            cfg_wr;
    t_cfg            cfg;
    logic            fr_valid;
    t_item           fr_item;
    logic            q_ready;
    logic            q_valid;
    t_item           q_item;
    logic            q_pop;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len    <= WIN_LEN_RST;
            r_bin_count  <= BIN_COUNT_RST;
            r_top_weight <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                CFG_WIN_LEN:    r_win_len    <= i_cfg.data[K_W-1:0];
                CFG_BIN_COUNT:  r_bin_count  <= i_cfg.data[TC_W-1:0];
                CFG_TOP_WEIGHT: r_top_weight <= i_cfg.data[TW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.win_len      = r_win_len;
    assign cfg.bin_count    = r_bin_count;
    assign cfg.top_weight   = r_top_weight;
    assign cfg.weight_stale = cfg_wr && ((i_cfg.index == CFG_BIN_COUNT)
                                      || (i_cfg.index == CFG_TOP_WEIGHT));

    rkcb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (fr_valid),
        .o_item  (fr_item),
        .i_ready (q_ready)
    );

    rkcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_item  (fr_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    rkcb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== src/rkcb_front.sv =====
// ----------------------------------------------------------------------------
// rkcb_front: input stage
// Takes a character word, classifies it into a 2-bit base code or a bad
// character, and holds the classified word for the queue.
// ----------------------------------------------------------------------------
module rkcb_front import rkcb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rkcb_in_if.sink   i_in,
    output logic      o_valid,
    output t_item     o_item,
    input  logic      i_ready
);

    logic  r_valid;
    t_item r_item;

    function automatic t_item classify(input logic [CHAR_W-1:0] c, input logic mn);
        t_item it;
        it.minimize = mn;
        it.bad      = 1'b0;
        unique case (c)
            CHAR_A: it.code = BASE_A;
            CHAR_C: it.code = BASE_C;
            CHAR_G: it.code = BASE_G;
            CHAR_T: it.code = BASE_T;
            default: begin
                it.code = BASE_A;
                it.bad  = 1'b1;
            end
        endcase
        return it;
    endfunction

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= classify(i_in.base_char, i_in.minimize);
        end
    end

endmodule

// ===== src/rkcb_queue.sv =====
// ----------------------------------------------------------------------------
// rkcb_queue: word queue between front and back
// Small register queue so that the front keeps taking words while the back
// works or waits on the result channel.
// ----------------------------------------------------------------------------
module rkcb_queue import rkcb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + QCNT_W'(1))
        else $error("queue count missed a push");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count == $past(r_count) - QCNT_W'(1))
        else $error("queue count missed a pop");
`endif

endmodule

// ===== src/rkcb_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rkcb_mod_unit: iterative remainder unit
// Restoring remainder of a 16-bit operand by the binning modulus, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module rkcb_mod_unit import rkcb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [BIN_W-1:0] i_operand,
    input  logic [TC_W-1:0]  i_modulus,
    output logic             o_done,
    output logic [BIN_W-1:0] o_result
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [BIN_W-1:0]     r_x;
    logic [TC_W-1:0]      r_rem;
    logic [TC_W:0]        shifted;
    logic [TC_W-1:0]      n_rem;

    always_comb begin
        shifted = {r_rem, r_x[BIN_W-1]};
        if (shifted >= {1'b0, i_modulus}) begin
            n_rem = TC_W'(shifted - {1'b0, i_modulus});
        end else begin
            n_rem = TC_W'(shifted);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_rem[BIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_operand;
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= r_x << 1;
            r_rem <= n_rem;
        end
    end

endmodule

// ===== src/rkcb_back.sv =====
// ----------------------------------------------------------------------------
// rkcb_back: window and bin engine
// Shifts each base into the k-mer window, keeps the rolling bin residue,
// forms the reverse complement and canonical choice, and holds the result.
// ----------------------------------------------------------------------------
module rkcb_back import rkcb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    rkcb_out_if.source o_out
);

    typedef struct packed {
        logic [WIN_W-1:0]  forward_kmer;
        logic [WIN_W-1:0]  chosen_kmer;
        logic              was_reversed;
        logic [BIN_W-1:0]  bin_index;
        logic [CHAR_W-1:0] dropped_char;
        logic              bad_char;
    } t_result;

    t_state           r_state, n_state;
    logic [WIN_W-1:0] r_window, n_window;
    logic [BIN_W-1:0] r_residue, n_residue;
    logic             r_tw_ok, n_tw_ok;
    logic [BIN_W-1:0] r_tw_red, n_tw_red;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_code, n_code;
    logic             r_min, n_min;
    logic             r_bad, n_bad;
    logic [BIN_W-1:0] r_t, n_t;
    logic [BIN_W-1:0] r_sub, n_sub;
    logic [1:0]       r_left, n_left;
    t_result          r_out, n_out;
    logic             load_out;

    logic [K_W-1:0]   k_eff;
    logic [SH_W-1:0]  k2;
    logic [SH_W-1:0]  rc_shamt;
    logic [TC_W-1:0]  m_eff;
    logic [WIN_W-1:0] mask;
    logic [WIN_W-1:0] w_cur;
    logic [1:0]       left;
    logic [1:0]       code_sel;
    logic [WIN_W-1:0] win_next;
    logic [BIN_W-1:0] op_r;
    logic [RED_W-1:0] prod;
    logic             res_big;
    logic             step1;
    logic             out_free;
    logic [WIN_W-1:0] rc;
    logic [BIN_W-1:0] fin_res;
    logic [TC_W:0]    wrap_sum;
    logic             mod_start;
    logic [BIN_W-1:0] mod_operand;
    logic             mod_done;
    logic [BIN_W-1:0] mod_result;

    function automatic logic [BIN_W-1:0] reduce3(input logic [RED_W-1:0] x,
                                                 input logic [TC_W-1:0] m);
        logic [RED_W-1:0] m1;
        logic [RED_W-1:0] m2;
        logic [RED_W-1:0] m3;
        logic [RED_W-1:0] r;
        m1 = RED_W'(m);
        m2 = m1 << 1;
        m3 = m1 + m2;
        priority if (x >= m3) begin
            r = x - m3;
        end else if (x >= m2) begin
            r = x - m2;
        end else if (x >= m1) begin
            r = x - m1;
        end else begin
            r = x;
        end
        return r[BIN_W-1:0];
    endfunction

    function automatic logic [WIN_W-1:0] revcomp_full(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        for (int j = 0; j < MAX_K; j++) begin
            r[2*j +: 2] = ~w[2*(MAX_K-1-j) +: 2];
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] decode(input logic [1:0] b);
        logic [CHAR_W-1:0] c;
        unique case (b)
            BASE_A: c = CHAR_A;
            BASE_C: c = CHAR_C;
            BASE_G: c = CHAR_G;
            BASE_T: c = CHAR_T;
        endcase
        return c;
    endfunction

    // effective length and modulus
    always_comb begin
        if (i_cfg.win_len == '0) begin
            k_eff = K_W'(1);
        end else if (i_cfg.win_len > K_W'(MAX_K)) begin
            k_eff = K_W'(MAX_K);
        end else begin
            k_eff = i_cfg.win_len;
        end
        if (i_cfg.bin_count == '0) begin
            m_eff = TC_W'(1);
        end else if (i_cfg.bin_count > MAX_BINS) begin
            m_eff = MAX_BINS;
        end else begin
            m_eff = i_cfg.bin_count;
        end
    end

    assign k2       = SH_W'({k_eff, 1'b0});
    assign rc_shamt = SH_W'(WIN_W) - k2;
    assign mask     = {WIN_W{1'b1}} >> rc_shamt;
    assign w_cur    = r_window & mask;
    assign left     = 2'(w_cur >> (k2 - SH_W'(2)));
    assign code_sel = (r_state == ST_IDLE) ? i_q_item.code : r_code;
    assign win_next = ((w_cur << 2) | WIN_W'(code_sel)) & mask;
    assign op_r     = (r_state == ST_STEP1) ? mod_result : r_residue;
    assign prod     = (left[0] ? RED_W'(r_tw_red) : '0)
                    + (left[1] ? (RED_W'(r_tw_red) << 1) : '0);
    assign res_big  = ({1'b0, r_residue} >= m_eff);
    assign out_free = !r_out_valid || o_out.ready;
    assign rc       = revcomp_full(w_cur) >> rc_shamt;

    // final residue: t - sub modulo m
    always_comb begin
        wrap_sum = {2'b00, r_t} + {1'b0, m_eff} - {2'b00, r_sub};
        if (r_t >= r_sub) begin
            fin_res = r_t - r_sub;
        end else begin
            fin_res = wrap_sum[BIN_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_residue   = r_residue;
        n_tw_ok     = r_tw_ok;
        n_tw_red    = r_tw_red;
        n_code      = r_code;
        n_min       = r_min;
        n_bad       = r_bad;
        n_t         = r_t;
        n_sub       = r_sub;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        load_out    = 1'b0;
        o_q_pop     = 1'b0;
        mod_start   = 1'b0;
        mod_operand = '0;
        step1       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_code  = i_q_item.code;
                    n_min   = i_q_item.minimize;
                    n_bad   = i_q_item.bad;
                    priority if (i_q_item.bad) begin
                        n_state = ST_FIN;
                    end else if (!r_tw_ok) begin
                        mod_start   = 1'b1;
                        mod_operand = i_cfg.top_weight;
                        n_state     = ST_TWRED;
                    end else if (res_big) begin
                        mod_start   = 1'b1;
                        mod_operand = r_residue;
                        n_state     = ST_RRED;
                    end else begin
                        step1   = 1'b1;
                        n_state = ST_FIN;
                    end
                end
            end
            ST_TWRED: begin
                if (mod_done) begin
                    n_tw_red = mod_result;
                    n_tw_ok  = 1'b1;
                    n_state  = ST_PREP;
                end
            end
            ST_PREP: begin
                if (res_big) begin
                    mod_start   = 1'b1;
                    mod_operand = r_residue;
                    n_state     = ST_RRED;
                end else begin
                    step1   = 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_RRED: begin
                if (mod_done) begin
                    n_state = ST_STEP1;
                end
            end
            ST_STEP1: begin
                step1   = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    load_out           = 1'b1;
                    n_out_valid        = 1'b1;
                    n_out.forward_kmer = w_cur;
                    if (r_min && (w_cur < rc)) begin
                        n_out.chosen_kmer  = w_cur;
                        n_out.was_reversed = 1'b0;
                    end else begin
                        n_out.chosen_kmer  = rc;
                        n_out.was_reversed = 1'b1;
                    end
                    n_out.bad_char = r_bad;
                    if (r_bad) begin
                        n_out.bin_index    = r_residue;
                        n_out.dropped_char = '0;
                    end else begin
                        n_out.bin_index    = fin_res;
                        n_out.dropped_char = decode(r_left);
                        n_residue          = fin_res;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (step1) begin
            n_window = win_next;
            n_left   = left;
            n_t      = reduce3({1'b0, op_r, code_sel}, m_eff);
            n_sub    = reduce3(prod, m_eff);
        end

        if (i_cfg.weight_stale) begin
            n_tw_ok = 1'b0;
        end
    end

    rkcb_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_operand (mod_operand),
        .i_modulus (m_eff),
        .o_done    (mod_done),
        .o_result  (mod_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= '0;
            r_residue   <= '0;
            r_tw_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_residue   <= n_residue;
            r_tw_ok     <= n_tw_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tw_red <= n_tw_red;
        r_code   <= n_code;
        r_min    <= n_min;
        r_bad    <= n_bad;
        r_t      <= n_t;
        r_sub    <= n_sub;
        r_left   <= n_left;
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.forward_kmer = r_out.forward_kmer;
    assign o_out.chosen_kmer  = r_out.chosen_kmer;
    assign o_out.was_reversed = r_out.was_reversed;
    assign o_out.bin_index    = r_out.bin_index;
    assign o_out.dropped_char = r_out.dropped_char;
    assign o_out.bad_char     = r_out.bad_char;

`ifndef SYNTH
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && out_free |=> r_out_valid)
        else $error("finished word not placed in output register");
    a_twred_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TWRED) |-> !r_tw_ok)
        else $error("weight reduction running with a valid reduced weight");
    a_bad_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && r_bad && ($past(r_state) == ST_IDLE)
            |-> $stable(r_window) && $stable(r_residue))
        else $error("bad character changed window or residue");
`endif

endmodule
